// ===== rtl/core/hwrc_pkg.sv =====
// Shared types and constants for the homogeneous word run coalescer.
`timescale 1ns / 1ps
`default_nettype none

package hwrc_pkg;

  localparam int DATA_W  = 64;  // width of a word field
  localparam int BITS_W  = 25;  // width of a run length field
  localparam int VBITS_W = 7;   // width of the valid bit count

  localparam int     WORD_BITS    = 64;
  localparam longint MAX_RUN_BITS = 64'd16777216;

  // Whole words after which a run is cut.
  localparam longint MAX_RUN_WORDS = (MAX_RUN_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int     CNT_W         = $clog2(MAX_RUN_WORDS);

  localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);

  // Result buffer depth; an item can add two results.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0]  block_word;
    logic               is_last;
    logic [VBITS_W-1:0] valid_bits;
  } word_t;

  typedef struct packed {
    logic [DATA_W-1:0] run_value;
    logic [BITS_W-1:0] run_bits;
    logic              run_last;
  } run_t;

endpackage

`default_nettype wire

// ===== rtl/core/homogeneous_word_run_coalescer.sv =====
// Top level of the homogeneous word run coalescer.
`timescale 1ns / 1ps
`default_nettype none

// Word-aligned run-length coalescer. Bitmap words arrive one per transfer on
// the word channel; neighboring all-zero words, or neighboring all-one words,
// merge into one run, and each run or mixed word leaves as one transfer on the
// run channel carrying its pattern and its length in bits. The word flagged
// is_last closes the bitmap: it joins a pending run when its valid bits match,
// otherwise the run is flushed first and the word follows with its own valid
// bit count (0 or anything above 64 counts as 64). Runs are cut at
// MAX_RUN_BITS. Timing: a word is taken into an input register, decoded
// combinationally from there, and its zero, one or two results are written
// into a 4-entry result buffer once that buffer has room for two results.
// One word per cycle is sustained; word_ready drops only when the result
// buffer has fewer than two free entries, i.e. when the run side stalls or
// a word yields two results back to back.
module homogeneous_word_run_coalescer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            word_valid,
  output logic                 word_ready,
  input  wire hwrc_pkg::word_t word_data,
  output logic                 run_valid,
  input  wire logic            run_ready,
  output hwrc_pkg::run_t       run_data
);

  // Input register
  logic            q_valid;
  hwrc_pkg::word_t q;
  logic            advance;

  // Run state
  logic                       run_open;
  logic                       run_all_ones;
  logic [hwrc_pkg::CNT_W-1:0] run_word_count;
  logic                       run_open_next;
  logic                       run_all_ones_next;
  logic [hwrc_pkg::CNT_W-1:0] run_word_count_next;

  // Result buffer
  hwrc_pkg::run_t              fifo [hwrc_pkg::FIFO_DEPTH];
  logic [hwrc_pkg::PTR_W-1:0]  wr_ptr;
  logic [hwrc_pkg::PTR_W-1:0]  rd_ptr;
  logic [hwrc_pkg::FCNT_W-1:0] fcnt;
  logic                        pop;

  // Decode results
  hwrc_pkg::run_t r0;
  hwrc_pkg::run_t r1;
  logic [1:0]     n_res;

  // Decode helpers
  logic [hwrc_pkg::DATA_W-1:0]  w;
  logic [hwrc_pkg::DATA_W-1:0]  pattern;
  logic [hwrc_pkg::DATA_W-1:0]  vmask;
  logic [hwrc_pkg::VBITS_W-1:0] v_eff;
  logic [hwrc_pkg::BITS_W-1:0]  open_bits;
  logic [hwrc_pkg::CNT_W:0]     new_cnt;
  logic                         ones;
  logic                         flush;
  logic                         at_limit;
  hwrc_pkg::run_t               flush_res;
  hwrc_pkg::run_t               limit_res;

  // Input stage moves on only when the buffer can take two results.
  assign advance    = q_valid && (fcnt <= hwrc_pkg::FCNT_W'(hwrc_pkg::FIFO_DEPTH - 2));
  assign word_ready = !q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (word_ready) begin
      q_valid <= word_valid;
    end
    if (word_ready && word_valid) begin
      q <= word_data;
    end
  end

  always_comb begin
    w       = q.block_word & hwrc_pkg::WORD_MASK;
    pattern = run_all_ones ? hwrc_pkg::WORD_MASK : '0;
    if (q.valid_bits == '0 ||
        q.valid_bits > hwrc_pkg::VBITS_W'(hwrc_pkg::WORD_BITS)) begin
      v_eff = hwrc_pkg::VBITS_W'(hwrc_pkg::WORD_BITS);
    end else begin
      v_eff = q.valid_bits;
    end
    for (int i = 0; i < hwrc_pkg::DATA_W; i++) begin
      vmask[i] = (i < int'(v_eff));
    end
    open_bits = hwrc_pkg::BITS_W'(run_word_count) *
                hwrc_pkg::BITS_W'(hwrc_pkg::WORD_BITS);
    ones      = (w != '0);

    flush_res.run_value = pattern;
    flush_res.run_bits  = open_bits;
    flush_res.run_last  = 1'b0;

    flush = 1'b0;
    if (run_open && (run_all_ones == ones)) begin
      new_cnt = {1'b0, run_word_count} + (hwrc_pkg::CNT_W+1)'(1);
    end else begin
      new_cnt = (hwrc_pkg::CNT_W+1)'(1);
    end
    at_limit = (new_cnt >= (hwrc_pkg::CNT_W+1)'(hwrc_pkg::MAX_RUN_WORDS));
    limit_res.run_value = ones ? hwrc_pkg::WORD_MASK : '0;
    limit_res.run_bits  = hwrc_pkg::BITS_W'(new_cnt) *
                          hwrc_pkg::BITS_W'(hwrc_pkg::WORD_BITS);
    limit_res.run_last  = 1'b0;

    r0                  = flush_res;
    r1                  = flush_res;
    n_res               = 2'd0;
    run_open_next       = 1'b0;
    run_all_ones_next   = 1'b0;
    run_word_count_next = '0;

    if (q.is_last) begin
      // Final word: join a matching run, else flush and emit it alone.
      if (run_open && ((w & vmask) == (pattern & vmask))) begin
        r0.run_bits = open_bits + hwrc_pkg::BITS_W'(v_eff);
        r0.run_last = 1'b1;
        n_res       = 2'd1;
      end else begin
        flush = run_open;
        r1.run_value = w;
        r1.run_bits  = hwrc_pkg::BITS_W'(v_eff);
        r1.run_last  = 1'b1;
        if (flush) begin
          n_res = 2'd2;
        end else begin
          r0    = r1;
          n_res = 2'd1;
        end
      end
    end else if (w == '0 || w == hwrc_pkg::WORD_MASK) begin
      // Homogeneous word: extend or restart the run, cut at the limit.
      flush = run_open && (run_all_ones != ones);
      if (flush && at_limit) begin
        r1    = limit_res;
        n_res = 2'd2;
      end else if (flush) begin
        n_res = 2'd1;
      end else if (at_limit) begin
        r0    = limit_res;
        n_res = 2'd1;
      end
      if (!at_limit) begin
        run_open_next       = 1'b1;
        run_all_ones_next   = ones;
        run_word_count_next = hwrc_pkg::CNT_W'(new_cnt);
      end
    end else begin
      // Mixed word: flush any run, then the word on its own.
      flush        = run_open;
      r1.run_value = w;
      r1.run_bits  = hwrc_pkg::BITS_W'(hwrc_pkg::WORD_BITS);
      r1.run_last  = 1'b0;
      if (flush) begin
        n_res = 2'd2;
      end else begin
        r0    = r1;
        n_res = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open       <= 1'b0;
      run_all_ones   <= 1'b0;
      run_word_count <= '0;
    end else if (advance) begin
      run_open       <= run_open_next;
      run_all_ones   <= run_all_ones_next;
      run_word_count <= run_word_count_next;
    end
  end

  // Result buffer: up to two writes per cycle, one read.
  assign pop       = run_valid && run_ready;
  assign run_valid = (fcnt != '0);
  assign run_data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < hwrc_pkg::FIFO_DEPTH; i++) begin
        if (n_res != 2'd0 && wr_ptr == hwrc_pkg::PTR_W'(i)) begin
          fifo[i] <= r0;
        end
        if (n_res == 2'd2 && wr_ptr + hwrc_pkg::PTR_W'(1) == hwrc_pkg::PTR_W'(i)) begin
          fifo[i] <= r1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcnt   <= '0;
    end else begin
      if (advance) begin
        wr_ptr <= wr_ptr + hwrc_pkg::PTR_W'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hwrc_pkg::PTR_W'(1);
      end
      fcnt <= fcnt + (advance ? hwrc_pkg::FCNT_W'(n_res) : '0) -
              hwrc_pkg::FCNT_W'(pop);
    end
  end

  // Buffer never overfills.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fcnt <= hwrc_pkg::FCNT_W'(hwrc_pkg::FIFO_DEPTH))
    else $error("result buffer overflow");

  // No pending run means an empty word count.
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !run_open |-> run_word_count == '0)
    else $error("word count held without an open run");

  // Run never reaches the cut length while pending.
  a_run_limit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, run_word_count} < (hwrc_pkg::CNT_W+1)'(hwrc_pkg::MAX_RUN_WORDS))
    else $error("pending run at or past the limit");

  // A final word always closes the run.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    advance && q.is_last |=> !run_open)
    else $error("run left open after final word");

endmodule

`default_nettype wire
